@@ hdl/key_matrix_event_player_unit_assert.svh @@
`ifndef KEY_MATRIX_EVENT_PLAYER_UNIT_ASSERT_SVH
`define KEY_MATRIX_EVENT_PLAYER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KMEP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/kmep_pkg.sv @@
package kmep_pkg;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_CAPS = 2'd3
  } kmep_op_t;

  localparam logic [1:0] CLS_PLAIN  = 2'd0;
  localparam logic [1:0] CLS_SYMBOL = 2'd1;
  localparam logic [1:0] CLS_UPPER  = 2'd2;
  localparam logic [1:0] CLS_LOWER  = 2'd3;

  localparam logic [7:0] ROW_SHIFT = 8'hFE;
  localparam logic [2:0] BIT_SHIFT = 3'd0;
  localparam logic [7:0] ROW_MODE  = 8'hFB;
  localparam logic [2:0] BIT_MODE  = 3'd4;
  localparam logic [7:0] IDLE_DATA = 8'hFF;
  localparam logic [7:0] DROP_MAX  = 8'hFF;
  localparam logic [7:0] HOLD_RESET = 8'd3;

  localparam int SEQ_LEN = 5;

  typedef struct packed {
    kmep_op_t   operation;
    logic [7:0] row_code;
    logic [2:0] key_bit;
    logic [1:0] shift_class;
    logic       release_req;
  } kmep_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [5:0] queue_level;
    logic [7:0] dropped_count;
  } kmep_out_t;

  typedef struct packed {
    logic [7:0] row;
    logic       rel;
    logic [2:0] bit_pos;
  } kmep_entry_t;

  typedef struct packed {
    logic        en;
    kmep_entry_t entry;
  } kmep_upd_t;

endpackage

@@ hdl/key_matrix_event_player_unit.sv @@
// Channel   Ports                              Handshake
// input     start, busy, in_data               start && !busy
// result    out_valid, out_data                one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_data     cfg_valid && cfg_ready
//
// Port reads, caps lock toggles and ticks that pop nothing finish in ST_IDLE.
// A popping tick passes ST_TICK_RD and ST_TICK_WR, for the queue memory's registered read.
// A key event passes ST_PUSH once per entry of its sequence, one to five entries.
// The result strobe follows in the cycle after the last step; the receiver
// cannot stall. Reset is synchronous and needs no clearing pass.
module key_matrix_event_player_unit
  import kmep_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  kmep_in_t   in_data,
  output logic       out_valid,
  output kmep_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  `include "key_matrix_event_player_unit_assert.svh"

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PUSH    = 4'b0010,
    ST_TICK_RD = 4'b0100,
    ST_TICK_WR = 4'b1000
  } kmep_state_t;

  kmep_state_t state_r, state_nxt;
  kmep_entry_t seq_r [SEQ_LEN];
  kmep_entry_t seq_nxt [SEQ_LEN];
  kmep_entry_t seq_b [SEQ_LEN];
  logic [2:0]  len_r, len_nxt, len_b;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]  pace_r, pace_nxt;
  logic        shift_r, shift_nxt, mode_r, mode_nxt, caps_r, caps_nxt;
  logic [7:0]  drop_r, drop_nxt;
  logic [7:0]  hold_r;
  logic        out_valid_r, out_valid_nxt;
  kmep_out_t   out_r, out_nxt;
  logic [1:0]  cls_eff;
  logic        toggle;
  kmep_entry_t key_entry;
  logic        ram_we, ram_re;
  kmep_entry_t ram_rd_data;
  kmep_upd_t   upd;
  logic [7:0]  port_data;

  kmep_event_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r),
    .wr_data (seq_r[0]),
    .rd_en   (ram_re),
    .rd_addr (rp_r),
    .rd_data (ram_rd_data)
  );

  kmep_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .rd_addr (in_data.row_code),
    .rd_data (port_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [2:0] k;
    k = 3'd0;
    cls_eff = in_data.shift_class;
    if (caps_r && in_data.shift_class[1]) begin
      cls_eff = in_data.shift_class ^ 2'd1;
    end
    toggle = ((cls_eff == CLS_UPPER) && mode_r) || ((cls_eff == CLS_LOWER) && !mode_r);
    key_entry = '{row: in_data.row_code, rel: in_data.release_req,
                  bit_pos: in_data.key_bit};
    for (int i = 0; i < SEQ_LEN; i++) begin
      seq_b[i] = key_entry;
    end
    if (toggle) begin
      if (!shift_r) begin
        seq_b[k] = '{row: ROW_SHIFT, rel: 1'b0, bit_pos: BIT_SHIFT};
        k = k + 3'd1;
      end
      seq_b[k] = '{row: ROW_MODE, rel: 1'b0, bit_pos: BIT_MODE};
      k = k + 3'd1;
      seq_b[k] = '{row: ROW_MODE, rel: 1'b1, bit_pos: BIT_MODE};
      k = k + 3'd1;
      seq_b[k] = '{row: ROW_SHIFT, rel: 1'b1, bit_pos: BIT_SHIFT};
      k = k + 3'd1;
    end else if (cls_eff == CLS_SYMBOL) begin
      if (!shift_r) begin
        seq_b[k] = '{row: ROW_SHIFT, rel: 1'b0, bit_pos: BIT_SHIFT};
        k = k + 3'd1;
      end
    end else if (shift_r) begin
      seq_b[k] = '{row: ROW_SHIFT, rel: 1'b1, bit_pos: BIT_SHIFT};
      k = k + 3'd1;
    end
    seq_b[k] = key_entry;
    len_b = k + 3'd1;
  end

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    len_nxt       = len_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    count_nxt     = count_r;
    pace_nxt      = pace_r;
    shift_nxt     = shift_r;
    mode_nxt      = mode_r;
    caps_nxt      = caps_r;
    drop_nxt      = drop_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    upd.en        = 1'b0;
    upd.entry     = ram_rd_data;
    out_nxt.read_data = IDLE_DATA;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.operation)
            OP_KEY: begin
              seq_nxt = seq_b;
              len_nxt = len_b;
              if (toggle) begin
                shift_nxt = 1'b0;
                mode_nxt  = !mode_r;
              end else begin
                shift_nxt = (cls_eff == CLS_SYMBOL);
              end
              state_nxt = ST_PUSH;
            end
            OP_TICK: begin
              if ((count_r != '0) && (pace_r == 8'd0)) begin
                state_nxt = ST_TICK_RD;
              end else begin
                if (pace_r != 8'd0) begin
                  pace_nxt = pace_r - 8'd1;
                end
                out_valid_nxt = 1'b1;
              end
            end
            OP_READ: begin
              out_nxt.read_data = port_data;
              out_valid_nxt     = 1'b1;
            end
            OP_CAPS: begin
              caps_nxt      = !caps_r;
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_PUSH: begin
        if (count_r == CNT_FULL) begin
          if (drop_r != DROP_MAX) begin
            drop_nxt = drop_r + 8'd1;
          end
        end else begin
          ram_we    = 1'b1;
          wp_nxt    = (wp_r == PTR_LAST) ? '0 : wp_r + PW'(1);
          count_nxt = count_r + CW'(1);
        end
        for (int i = 0; i < SEQ_LEN - 1; i++) begin
          seq_nxt[i] = seq_r[i + 1];
        end
        len_nxt = len_r - 3'd1;
        if (len_r == 3'd1) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_TICK_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_TICK_WR;
      end
      ST_TICK_WR: begin
        upd.en        = 1'b1;
        rp_nxt        = (rp_r == PTR_LAST) ? '0 : rp_r + PW'(1);
        count_nxt     = count_r - CW'(1);
        pace_nxt      = (hold_r == 8'd0) ? 8'd0 : hold_r - 8'd1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_nxt.queue_level   = 6'(count_nxt);
    out_nxt.dropped_count = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= 3'd0;
      wp_r        <= '0;
      rp_r        <= '0;
      count_r     <= '0;
      pace_r      <= 8'd0;
      shift_r     <= 1'b0;
      mode_r      <= 1'b0;
      caps_r      <= 1'b0;
      drop_r      <= 8'd0;
      hold_r      <= HOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      count_r     <= count_nxt;
      pace_r      <= pace_nxt;
      shift_r     <= shift_nxt;
      mode_r      <= mode_nxt;
      caps_r      <= caps_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        hold_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    out_r <= out_nxt;
  end

  `KMEP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL,
    "Queue count exceeds the queue depth.")
  `KMEP_ASSERT_NOW(a_ptr_match, clk, rst_n, 1'b1,
    (wp_r == rp_r) == ((count_r == '0) || (count_r == CNT_FULL)),
    "Queue pointers disagree with the entry count.")
  `KMEP_ASSERT_NOW(a_pop_nonempty, clk, rst_n, state_r == ST_TICK_WR, count_r != '0,
    "A pop was started on an empty queue.")
  `KMEP_ASSERT_NEXT(a_key_push, clk, rst_n,
    (state_r == ST_IDLE) && start && (in_data.operation == OP_KEY),
    (state_r == ST_PUSH) && (len_r != 3'd0),
    "A key event request did not start a push sequence.")

endmodule

@@ hdl/kmep_event_ram.sv @@
module kmep_event_ram
  import kmep_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  kmep_entry_t wr_data,
  input  logic        rd_en,
  input  logic [AW-1:0] rd_addr,
  output kmep_entry_t rd_data
);

  kmep_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/kmep_matrix.sv @@
module kmep_matrix
  import kmep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  kmep_upd_t  upd,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);

  logic [7:0] rows_r [8];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (!rst_n) begin
        rows_r[i] <= 8'hFF;
      end else if (upd.en && (upd.entry.row == ~(8'd1 << i))) begin
        rows_r[i][upd.entry.bit_pos] <= upd.entry.rel;
      end
    end
  end

  always_comb begin
    rd_data = 8'hFF;
    for (int i = 0; i < 8; i++) begin
      if (!rd_addr[i]) begin
        rd_data = rd_data & rows_r[i];
      end
    end
  end

endmodule

@@ tb/sv/tb_key_matrix_event_player_unit.sv @@
`timescale 1ns / 100ps
module tb_key_matrix_event_player_unit;
  import kmep_pkg::*;

  localparam int QUEUE_DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 386;
  localparam int PHASES = 5;

  typedef struct {
    kmep_in_t  req;
    bit        typed;
    kmep_out_t want;
  } directed_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  kmep_in_t   in_data = '0;
  logic       out_valid;
  kmep_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  logic [7:0]  rows_model [8];
  kmep_entry_t events_model [$];
  logic [7:0]  hold_model;
  logic [7:0]  pace_model;
  logic [7:0]  drops_model;
  logic        shift_down;
  logic        mode_on;
  logic        caps_on;
  kmep_out_t   pending_results [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  directed_row_t directed_rows [22] = '{
    '{'{OP_READ, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b1, '{8'hFF, 6'd0,  8'd0}},
    '{'{OP_TICK, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b1, '{8'hFF, 6'd0,  8'd0}},
    '{'{OP_CAPS, 8'hFF, 3'd7, CLS_LOWER,  1'b1}, 1'b1, '{8'hFF, 6'd0,  8'd0}},
    '{'{OP_CAPS, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b1, '{8'hFF, 6'd0,  8'd0}},
    '{'{OP_KEY,  8'h7F, 3'd7, CLS_LOWER,  1'b0}, 1'b1, '{8'hFF, 6'd5,  8'd0}},
    '{'{OP_KEY,  8'hFE, 3'd1, CLS_UPPER,  1'b1}, 1'b1, '{8'hFF, 6'd10, 8'd0}},
    '{'{OP_KEY,  8'hFD, 3'd2, CLS_LOWER,  1'b0}, 1'b1, '{8'hFF, 6'd15, 8'd0}},
    '{'{OP_KEY,  8'hBF, 3'd3, CLS_UPPER,  1'b0}, 1'b1, '{8'hFF, 6'd20, 8'd0}},
    '{'{OP_KEY,  8'hEF, 3'd5, CLS_LOWER,  1'b1}, 1'b1, '{8'hFF, 6'd25, 8'd0}},
    '{'{OP_KEY,  8'hDF, 3'd6, CLS_UPPER,  1'b0}, 1'b1, '{8'hFF, 6'd30, 8'd0}},
    '{'{OP_KEY,  8'hF7, 3'd7, CLS_LOWER,  1'b0}, 1'b1, '{8'hFF, 6'd32, 8'd3}},
    '{'{OP_KEY,  8'hFB, 3'd0, CLS_SYMBOL, 1'b0}, 1'b0, '0},
    '{'{OP_TICK, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0},
    '{'{OP_TICK, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0},
    '{'{OP_TICK, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0},
    '{'{OP_TICK, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0},
    '{'{OP_READ, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0},
    '{'{OP_READ, 8'hFF, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0},
    '{'{OP_CAPS, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0},
    '{'{OP_KEY,  8'h00, 3'd0, CLS_UPPER,  1'b0}, 1'b0, '0},
    '{'{OP_KEY,  8'hFF, 3'd7, CLS_PLAIN,  1'b1}, 1'b0, '0},
    '{'{OP_CAPS, 8'h00, 3'd0, CLS_PLAIN,  1'b0}, 1'b0, '0}
  };

  logic [7:0] phase_hold [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd0, HOLD_RESET};
  int         phase_key_pct [PHASES] = '{15, 30, 15, 10, 10};

  key_matrix_event_player_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task report_mismatch(input string what, input kmep_out_t got, input kmep_out_t want);
    mismatches++;
    $display("%0t mismatch on %s: got %h/%0d/%0d, want %h/%0d/%0d", $time, what,
             got.read_data, got.queue_level, got.dropped_count,
             want.read_data, want.queue_level, want.dropped_count);
  endtask

  task enqueue_event(input logic [7:0] code, input logic [2:0] pos, input logic rel);
    if (events_model.size() >= QUEUE_DEPTH) begin
      if (drops_model != DROP_MAX) drops_model++;
    end else begin
      events_model.push_back('{row: code, rel: rel, bit_pos: pos});
    end
  endtask

  task release_shift();
    if (shift_down) begin
      enqueue_event(ROW_SHIFT, BIT_SHIFT, 1'b1);
      shift_down = 1'b0;
    end
  endtask

  task toggle_mode_events();
    if (!shift_down) enqueue_event(ROW_SHIFT, BIT_SHIFT, 1'b0);
    enqueue_event(ROW_MODE, BIT_MODE, 1'b0);
    enqueue_event(ROW_MODE, BIT_MODE, 1'b1);
    enqueue_event(ROW_SHIFT, BIT_SHIFT, 1'b1);
    shift_down = 1'b0;
  endtask

  task play_request(input kmep_in_t req, output kmep_out_t res);
    logic [1:0]  cls;
    kmep_entry_t head;
    logic [7:0]  data;
    int          i;
    data = IDLE_DATA;
    case (req.operation)
      OP_KEY: begin
        cls = req.shift_class;
        if (caps_on && (cls == CLS_UPPER || cls == CLS_LOWER)) cls = cls ^ 2'd1;
        case (cls)
          CLS_PLAIN: release_shift();
          CLS_SYMBOL: begin
            if (!shift_down) begin
              enqueue_event(ROW_SHIFT, BIT_SHIFT, 1'b0);
              shift_down = 1'b1;
            end
          end
          CLS_UPPER: begin
            if (mode_on) begin
              toggle_mode_events();
              mode_on = 1'b0;
            end else begin
              release_shift();
            end
          end
          default: begin
            if (!mode_on) begin
              toggle_mode_events();
              mode_on = 1'b1;
            end else begin
              release_shift();
            end
          end
        endcase
        enqueue_event(req.row_code, req.key_bit, req.release_req);
      end
      OP_TICK: begin
        if (events_model.size() != 0 && pace_model == 8'd0) begin
          head = events_model.pop_front();
          for (i = 0; i < 8; i++) begin
            if (head.row == ~(8'd1 << i)) rows_model[i][head.bit_pos] = head.rel;
          end
          pace_model = hold_model;
        end
        if (pace_model != 8'd0) pace_model--;
      end
      OP_READ: begin
        for (i = 0; i < 8; i++) begin
          if (!req.row_code[i]) data &= rows_model[i];
        end
      end
      default: caps_on = !caps_on;
    endcase
    res.read_data = data;
    res.queue_level = 6'(events_model.size());
    res.dropped_count = drops_model;
  endtask

  function int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  function kmep_in_t random_request(input int key_pct);
    kmep_in_t req;
    int       roll;
    roll = $urandom_range(0, 99);
    req.row_code = 8'($urandom_range(0, 255));
    req.key_bit = 3'($urandom_range(0, 7));
    req.shift_class = 2'($urandom_range(0, 3));
    req.release_req = 1'($urandom_range(0, 1));
    if (roll < key_pct) begin
      req.operation = OP_KEY;
      if ($urandom_range(0, 4) != 0) req.row_code = ~(8'd1 << $urandom_range(0, 7));
    end else if (roll < key_pct + 5) begin
      req.operation = OP_CAPS;
    end else if (roll < key_pct + 20) begin
      req.operation = OP_READ;
      if ($urandom_range(0, 1) != 0) req.row_code = ~(8'd1 << $urandom_range(0, 7));
    end else begin
      req.operation = OP_TICK;
    end
    return req;
  endfunction

  task send_request(input kmep_in_t req, input bit typed, input kmep_out_t want,
                    input int gap);
    kmep_out_t predicted;
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    play_request(req, predicted);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task write_hold(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    hold_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    kmep_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result", out_data, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data, want);
        if (out_data.queue_level !== want.queue_level)
          report_mismatch("queue_level", out_data, want);
        if (out_data.dropped_count !== want.dropped_count)
          report_mismatch("dropped_count", out_data, want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] hold_value;
    int         r;
    int         p;
    int         n;
    for (r = 0; r < 8; r++) rows_model[r] = 8'hFF;
    hold_model = HOLD_RESET;
    pace_model = 8'd0;
    drops_model = 8'd0;
    shift_down = 1'b0;
    mode_on = 1'b0;
    caps_on = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (r = 0; r < 22; r++) begin
      send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want,
                   draw_gap());
    end
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      hold_value = (p == 3) ? 8'($urandom_range(2, 254)) : phase_hold[p];
      write_hold(hold_value);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) == 0) wait_idle();
        send_request(random_request(phase_key_pct[p]), 1'b0, '0, draw_gap());
      end
    end
    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/kmep_pkg.sv
hdl/kmep_event_ram.sv
hdl/kmep_matrix.sv
hdl/key_matrix_event_player_unit.sv
tb/sv/tb_key_matrix_event_player_unit.sv
